>>> design/assert_macros.svh
// assertion helpers for the design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/ssr_pkg.sv
package ssr_pkg;

    localparam int SUM_MAX_DEF = 255;
    localparam int SHAMT_W     = 12;
    localparam int VALUE_W     = 16;
    localparam int TARGET_W    = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               add;
        logic [SHAMT_W-1:0] shamt;
        logic               last;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_beat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> design/ssr_front.sv
module ssr_front #(
    parameter int MAX_SUM = ssr_pkg::SUM_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ssr_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_no_element,
    input  logic                        i_last,
    output ssr_pkg::t_op_beat           o_beat,
    input  logic                        i_q_ready
);
    import ssr_pkg::*;

    logic r_valid;
    logic n_valid;
    t_op  r_op;
    t_op  n_op;
    logic in_range;

    assign in_range = (i_value != '0) && (i_value <= VALUE_W'(MAX_SUM));
    assign o_ready  = !r_valid || i_q_ready;

    always_comb begin
        n_valid = r_valid;
        n_op    = r_op;
        if (i_valid && o_ready) begin
            n_valid    = 1'b1;
            n_op.add   = !i_no_element && in_range;
            n_op.shamt = i_value[SHAMT_W-1:0];
            n_op.last  = i_last;
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    assign o_beat.valid = r_valid;
    assign o_beat.op    = r_op;

endmodule

>>> design/ssr_queue.sv
module ssr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssr_pkg::t_op_beat i_beat,
    output logic              o_ready,
    output ssr_pkg::t_op_beat o_beat,
    input  logic              i_pop,
    output ssr_pkg::t_qstat   o_stat
);
    import ssr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_op           r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    assign full    = (r_count == CW'(QUEUE_DEPTH));
    assign empty   = (r_count == '0);
    assign o_ready = !full;
    assign push    = i_beat.valid && !full;
    assign pop     = i_pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_beat.op;
        end
    end

    assign o_beat.valid = !empty;
    assign o_beat.op    = r_mem[r_rd];
    assign o_stat.full  = full;
    assign o_stat.empty = empty;

endmodule

>>> design/ssr_back.sv
module ssr_back #(
    parameter int MAX_SUM = ssr_pkg::SUM_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssr_pkg::t_op_beat            i_beat,
    output logic                         o_ready,
    input  logic [ssr_pkg::TARGET_W-1:0] i_target,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_found
);
    import ssr_pkg::*;

    localparam int W  = MAX_SUM + 1;
    localparam int SW = $clog2(W);
    localparam int TW = (SW > TARGET_W) ? SW : TARGET_W;
    localparam int CW = (TW > VALUE_W) ? TW : VALUE_W;

    logic [W-1:0]  r_vec;
    logic [W-1:0]  n_vec;
    logic          r_out_valid;
    logic          r_found;
    logic          fire;
    logic [TW-1:0] tgt_ext;
    logic          tgt_ok;
    logic          found;

    assign o_ready = !(i_beat.op.last && r_out_valid && !i_ready);
    assign fire    = i_beat.valid && o_ready;

    assign n_vec   = i_beat.op.add ? (r_vec | (r_vec << i_beat.op.shamt[SW-1:0])) : r_vec;
    assign tgt_ext = TW'(i_target);
    assign tgt_ok  = CW'(tgt_ext) <= CW'(MAX_SUM);
    assign found   = tgt_ok && n_vec[tgt_ext[SW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec       <= W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_vec <= i_beat.op.last ? W'(1) : n_vec;
            end
            if (fire && i_beat.op.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_beat.op.last) begin
            r_found <= found;
        end
    end

    assign o_valid = r_out_valid;
    assign o_found = r_found;

endmodule

>>> design/subset_sum_reachability.sv
// Subset-sum reachability. Takes one element beat per cycle while the back end is
// not stalled, and keeps a set of reachable sums 0..MAX_SUM in a bit vector; each
// element shifts the vector up by its value and ORs it in, combinationally in the
// back end. A beat with tlast produces one result beat on the master side (tdata
// bit 0 high if the target register's sum is reachable) and starts a fresh set.
// Sustained rate is one beat per cycle while no result is held unaccepted, with
// the shift-and-OR spanning the MAX_SUM+1 bit vector; a last beat passes the front
// register, the queue and the back end's output register before its result is on
// tvalid. A last beat waits in the queue while the previous result is still
// unaccepted. Elements above MAX_SUM or of value zero, and beats with tuser bit 0
// set, leave the set unchanged. A target above MAX_SUM is never found. The user
// must write the target on the cfg channel only while no beat is in flight; the
// block does not enforce this. Reset needs no clearing pass.
`include "assert_macros.svh"

module subset_sum_reachability #(
    parameter int MAX_SUM = ssr_pkg::SUM_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,   // element_value
    input  logic [0:0]                   s_axis_tuser,   // no_element
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // subset_found, zero pad
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ssr_pkg::TARGET_W-1:0] i_cfg_data
);
    import ssr_pkg::*;

    logic [TARGET_W-1:0] r_target;
    t_op_beat            f_beat;
    t_op_beat            q_beat;
    t_qstat              q_stat;
    logic                q_ready;
    logic                b_ready;
    logic                found;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid) begin
            r_target <= i_cfg_data;
        end
    end

    ssr_front #(.MAX_SUM(MAX_SUM)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_value      (s_axis_tdata),
        .i_no_element (s_axis_tuser[0]),
        .i_last       (s_axis_tlast),
        .o_beat       (f_beat),
        .i_q_ready    (q_ready)
    );

    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (f_beat),
        .o_ready (q_ready),
        .o_beat  (q_beat),
        .i_pop   (b_ready),
        .o_stat  (q_stat)
    );

    ssr_back #(.MAX_SUM(MAX_SUM)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (q_beat),
        .o_ready  (b_ready),
        .i_target (r_target),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_found  (found)
    );

    assign m_axis_tdata = {7'd0, found};

    `ASSERT_NEXT(a_front_drains, i_clk, i_rst_n, s_axis_tready && !s_axis_tvalid, !f_beat.valid)
    `ASSERT_IMPL(a_last_waits, i_clk, i_rst_n,
                 m_axis_tvalid && !m_axis_tready && q_beat.valid && q_beat.op.last, !b_ready)
    `ASSERT_IMPL(a_queue_flags, i_clk, i_rst_n, q_stat.full, !q_stat.empty && !q_ready)

endmodule

>>> sim/subset_sum_reachability_test.sv
`timescale 1ns / 1ps

module subset_sum_reachability_test;

    localparam int SUM_TOP     = ssr_pkg::SUM_MAX_DEF;
    localparam int ITEM_GOAL   = 1550;
    localparam int PHASES      = 8;
    localparam int SETTLE_CYC  = 8;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [15:0]                  s_axis_tdata = '0;    // element_value
    logic [0:0]                   s_axis_tuser = '0;    // no_element
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [7:0]                   m_axis_tdata;         // subset_found, zero pad
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [ssr_pkg::TARGET_W-1:0] i_cfg_data = '0;

    // predictor state
    logic [SUM_TOP:0]             reach_sums = 1;
    logic [ssr_pkg::TARGET_W-1:0] target_sum = '0;
    logic                         found_q[$];

    int   errors = 0;
    int   beats_sent = 0;
    bit   calm = 1'b0;
    int   stall_left = 0;
    logic want_found;

    subset_sum_reachability i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (found_q.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want_found = found_q.pop_front();
                if (m_axis_tdata[0] !== want_found) begin
                    $error("subset_found: expected %b, actual %b", want_found,
                           m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[7:1] !== 7'd0) begin
                    $error("tdata pad: expected %h, actual %h", 7'd0, m_axis_tdata[7:1]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [SUM_TOP:0] grow_sums(input logic [SUM_TOP:0] sums,
                                                   input logic [15:0] v,
                                                   input logic none);
        if (none || v == 0 || v > SUM_TOP)
            return sums;
        return sums | (sums << v);
    endfunction

    task automatic send_item(input logic [15:0] v, input logic none, input logic lst);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= none;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
        reach_sums = grow_sums(reach_sums, v, none);
        if (lst) begin
            found_q.push_back(target_sum <= SUM_TOP ? reach_sums[target_sum] : 1'b0);
            reach_sums = 1;
        end
    endtask

    // stop sending and let every outstanding beat drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (found_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [ssr_pkg::TARGET_W-1:0] t);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        target_sum = t;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1, 2:    return 16'($urandom_range(0, 255));
            3:       return 16'($urandom_range(0, 65535));
            4:       return 16'($urandom_range(256, 65535));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic send_random_set();
        int  len;
        logic none;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            none = ($urandom_range(0, 7) == 0);
            send_item(pick_value(), none, k == len - 1);
        end
    endtask

    task automatic test_reset_target();
        send_item(16'hA5A5, 1'b1, 1'b1);
        send_item(16'd7, 1'b0, 1'b1);
        settle();
    endtask

    task automatic test_extremes();
        write_target(8'd255);
        send_item(16'd255, 1'b0, 1'b1);
        send_item(16'd256, 1'b0, 1'b0);
        send_item(16'hFFFF, 1'b0, 1'b0);
        send_item(16'd0, 1'b0, 1'b0);
        send_item(16'h00FF, 1'b1, 1'b1);
        send_item(16'd128, 1'b0, 1'b0);
        send_item(16'd127, 1'b0, 1'b1);
        send_item(16'd200, 1'b0, 1'b0);
        send_item(16'd100, 1'b0, 1'b1);
        settle();
    endtask

    task automatic test_empty_and_ignored();
        write_target(8'd1);
        send_item(16'd0, 1'b1, 1'b1);
        send_item(16'd1, 1'b1, 1'b1);
        send_item(16'd0, 1'b0, 1'b0);
        send_item(16'd1, 1'b0, 1'b1);
        settle();
        write_target(8'd85);
        send_item(16'hFFFF, 1'b0, 1'b1);
        send_item(16'd40, 1'b0, 1'b0);
        send_item(16'd45, 1'b0, 1'b1);
        settle();
    endtask

    task automatic test_random_sets();
        int phase_end;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       write_target(8'd0);
                1:       write_target(8'd255);
                2:       write_target(8'($urandom_range(0, 255)));
                default: write_target(8'($urandom_range(1, 120)));
            endcase
            if (p == PHASES - 1)
                calm = 1'b1;
            phase_end = ITEM_GOAL * (p + 1) / PHASES;
            while (beats_sent < phase_end) begin
                send_random_set();
                // hold off until every pending result is back
                if (p == 3 && $urandom_range(0, 30) == 0)
                    settle();
            end
            settle();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_target();
        test_extremes();
        test_empty_and_ignored();
        test_random_sets();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
